>>> rtl/core/fast_inverse_square_root_assert.svh
// assertion macros used by the checker file
`ifndef FAST_INVERSE_SQUARE_ROOT_ASSERT_SVH
`define FAST_INVERSE_SQUARE_ROOT_ASSERT_SVH

// same-cycle implication
`define FISR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fisr assertion failed");

// next-cycle implication
`define FISR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fisr assertion failed");

`endif

>>> rtl/core/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// Constants and single-precision helper functions for the reciprocal
// square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fisr_pkg;

   localparam logic [31:0] MAGIC_GUESS   = 32'h5f3759df;
   localparam logic [31:0] ONE_HALF_BITS = 32'h3fc00000;
   localparam logic [31:0] HALF_BITS     = 32'h3f000000;
   localparam logic [31:0] DEFAULT_NAN   = 32'hffc00000;
   localparam logic [31:0] QUIET_BIT     = 32'h00400000;
   localparam logic [31:0] SIGN_BIT      = 32'h80000000;

   function automatic logic is_nan(logic [31:0] a);
      return a[30:0] > 31'h7f800000;
   endfunction

   function automatic logic is_inf(logic [31:0] a);
      return a[30:0] == 31'h7f800000;
   endfunction

   function automatic logic is_zero(logic [31:0] a);
      return a[30:0] == 31'h0;
   endfunction

   function automatic logic [23:0] unpack_man(logic [31:0] a);
      return (a[30:23] != 8'h0) ? {1'b1, a[22:0]} : {1'b0, a[22:0]};
   endfunction

   // exponent of the integer significand, subnormals share the smallest one
   function automatic logic signed [11:0] unpack_exp(logic [31:0] a);
      logic signed [11:0] ex;
      ex = $signed({4'b0, a[30:23]});
      return (a[30:23] != 8'h0) ? ex - 12'sd150 : -12'sd149;
   endfunction

   // index of the most significant set bit
   function automatic logic [5:0] lead_one(logic [63:0] m);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (m[i]) p = 6'(i);
      end
      return p;
   endfunction

   // round sign * m * 2^e to single, nearest even, m nonzero with msb at p
   function automatic logic [31:0] round_pack(logic sign, logic signed [11:0] e,
                                              logic [5:0] p, logic [63:0] m);
      logic signed [11:0] k;
      logic signed [11:0] sh;
      logic signed [11:0] field;
      logic [11:0]        neg;
      logic [7:0]         shc;
      logic [127:0]       wide;
      logic [63:0]        lft;
      logic [24:0]        q;
      k = $signed({6'b0, p}) + e - 12'sd23;
      if (k < -12'sd149) k = -12'sd149;
      sh = k - e;
      if (sh <= 12'sd0) begin
         neg = 12'(-sh);
         lft = m << neg[5:0];
         q = lft[24:0];
      end else begin
         shc = (sh > 12'sd128) ? 8'd128 : sh[7:0];
         wide = {m, 64'b0} >> shc;
         q = wide[88:64];
         if (wide[63] && ((|wide[62:0]) || q[0])) q = q + 25'd1;
      end
      if (q[24]) begin
         q = q >> 1;
         k = k + 12'sd1;
      end
      field = k + 12'sd150;
      if (q[23]) begin
         if (field >= 12'sd255) return {sign, 8'hff, 23'h0};
         return {sign, field[7:0], q[22:0]};
      end
      return {sign, 8'h0, q[22:0]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/fisr_fmul.sv
// ----------------------------------------------------------------------------
// fisr_fmul
// Three-stage single-precision multiplier: multiply, leading-one search,
// round and pack.
// ----------------------------------------------------------------------------
`default_nettype none

module fisr_fmul
   import fisr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [31:0] y
);

   logic               spec_in, spec1_ff, spec2_ff;
   logic [31:0]        sval_in, sval1_ff, sval2_ff;
   logic               sign_in, sign1_ff, sign2_ff;
   logic [47:0]        prod_in, prod1_ff;
   logic [63:0]        prod2_ff;
   logic signed [11:0] exp_in, exp1_ff, exp2_ff;
   logic [5:0]         lead_ff;
   logic [31:0]        y_ff;

   always_comb begin
      sign_in = a[31] ^ b[31];
      spec_in = 1'b1;
      sval_in = {sign_in, 31'h0};
      if (is_nan(a)) begin
         sval_in = a | QUIET_BIT;
      end else if (is_nan(b)) begin
         sval_in = b | QUIET_BIT;
      end else if (is_inf(a) || is_inf(b)) begin
         sval_in = (is_zero(a) || is_zero(b)) ? DEFAULT_NAN : {sign_in, 31'h7f800000};
      end else if (is_zero(a) || is_zero(b)) begin
         sval_in = {sign_in, 31'h0};
      end else begin
         spec_in = 1'b0;
      end
      prod_in = unpack_man(a) * unpack_man(b);
      exp_in  = unpack_exp(a) + unpack_exp(b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec1_ff <= spec_in;
         sval1_ff <= sval_in;
         sign1_ff <= sign_in;
         prod1_ff <= prod_in;
         exp1_ff  <= exp_in;
         spec2_ff <= spec1_ff;
         sval2_ff <= sval1_ff;
         sign2_ff <= sign1_ff;
         prod2_ff <= {16'b0, prod1_ff};
         exp2_ff  <= exp1_ff;
         lead_ff  <= lead_one({16'b0, prod1_ff});
         y_ff     <= spec2_ff ? sval2_ff : round_pack(sign2_ff, exp2_ff, lead_ff, prod2_ff);
      end
   end

   assign y = y_ff;

endmodule

`default_nettype wire

>>> rtl/core/fast_inverse_square_root.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Bit-exact single-precision reciprocal square root estimate with one
// Newton step.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle when the output is not stalled. The
// pipeline is four three-stage multipliers around a five-stage adder plus
// the output register; a stall on the result side freezes every stage at
// once, so req_tready follows rsp_tready whenever a result is waiting. A
// zero operand returns +0.
`default_nettype none

module fast_inverse_square_root
   import fisr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value_bits
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [31:0] recip_root_bits
);

   localparam int DEPTH = 18;

   logic              en;
   logic [DEPTH-1:0]  valid_ff;
   logic [31:0]       guess_ff [0:13];
   logic [DEPTH-2:0]  zero_ff;
   logic [31:0]       guess_in;
   logic [31:0]       x_w, xy_w, t_w, res_w;
   logic [31:0]       out_ff;

   assign en         = !valid_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en;
   assign guess_in   = MAGIC_GUESS - {req_tdata[31], req_tdata[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         guess_ff[0] <= guess_in;
         for (int i = 1; i < 14; i++) guess_ff[i] <= guess_ff[i-1];
         zero_ff <= {zero_ff[DEPTH-3:0], is_zero(req_tdata)};
      end
   end

   fisr_fmul u_half (.clock(clock), .en(en), .a(req_tdata), .b(HALF_BITS), .y(x_w));
   fisr_fmul u_xy   (.clock(clock), .en(en), .a(x_w), .b(guess_ff[2]), .y(xy_w));
   fisr_fmul u_xyy  (.clock(clock), .en(en), .a(xy_w), .b(guess_ff[5]), .y(t_w));

   // subtract 1.5 - t over five stages
   logic [31:0]        nb;
   logic               s1_spec_in, s1_spec_ff;
   logic [31:0]        s1_sval_in, s1_sval_ff;
   logic [23:0]        s1_bm_in, s1_bm_ff, s1_sm_in, s1_sm_ff;
   logic signed [11:0] s1_be_in, s1_be_ff, s1_se_in, s1_se_ff;
   logic               s1_sa_in, s1_sa_ff, s1_sb_in, s1_sb_ff;
   logic [23:0]        ma0, mb0;
   logic signed [11:0] ea0, eb0;

   always_comb begin
      nb = t_w ^ SIGN_BIT;
      s1_spec_in = 1'b1;
      s1_sval_in = ONE_HALF_BITS;
      if (is_nan(ONE_HALF_BITS)) begin
         s1_sval_in = ONE_HALF_BITS | QUIET_BIT;
      end else if (is_nan(t_w)) begin
         s1_sval_in = t_w | QUIET_BIT;
      end else if (is_inf(ONE_HALF_BITS)) begin
         s1_sval_in = (is_inf(nb) && (ONE_HALF_BITS[31] != nb[31])) ? DEFAULT_NAN
                                                                   : ONE_HALF_BITS;
      end else if (is_inf(nb)) begin
         s1_sval_in = nb;
      end else if (is_zero(ONE_HALF_BITS) && is_zero(nb)) begin
         s1_sval_in = ONE_HALF_BITS & nb & SIGN_BIT;
      end else if (is_zero(nb)) begin
         s1_sval_in = ONE_HALF_BITS;
      end else if (is_zero(ONE_HALF_BITS)) begin
         s1_sval_in = nb;
      end else begin
         s1_spec_in = 1'b0;
      end
      ma0 = unpack_man(ONE_HALF_BITS);
      mb0 = unpack_man(nb);
      ea0 = unpack_exp(ONE_HALF_BITS);
      eb0 = unpack_exp(nb);
      if ((eb0 > ea0) || ((eb0 == ea0) && (mb0 > ma0))) begin
         s1_bm_in = mb0; s1_be_in = eb0; s1_sa_in = nb[31];
         s1_sm_in = ma0; s1_se_in = ea0; s1_sb_in = ONE_HALF_BITS[31];
      end else begin
         s1_bm_in = ma0; s1_be_in = ea0; s1_sa_in = ONE_HALF_BITS[31];
         s1_sm_in = mb0; s1_se_in = eb0; s1_sb_in = nb[31];
      end
   end

   // alignment of the smaller operand with sticky
   logic signed [11:0] align_shift;
   logic [5:0]         align_shift_c;
   logic [117:0]       align_w;
   logic [53:0]        s2_mb_in, s2_mb_ff, s2_ma_ff;
   logic signed [11:0] s2_e_ff;
   logic               s2_sa_ff, s2_sb_ff, s2_spec_ff;
   logic [31:0]        s2_sval_ff;

   always_comb begin
      align_shift   = s1_be_ff - s1_se_ff;
      align_shift_c = (align_shift >= 12'sd63) ? 6'd63 : align_shift[5:0];
      align_w       = {s1_sm_ff, 30'b0, 64'b0} >> align_shift_c;
      s2_mb_in      = align_w[117:64] | {53'b0, |align_w[63:0]};
   end

   // add or subtract the aligned significands
   logic [54:0]        s3_sum_in;
   logic               s3_spec_in;
   logic [31:0]        s3_sval_in;
   logic [63:0]        s3_m_ff, s4_m_ff;
   logic signed [11:0] s3_e_ff, s4_e_ff;
   logic               s3_s_ff, s4_s_ff, s3_spec_ff, s4_spec_ff;
   logic [31:0]        s3_sval_ff, s4_sval_ff, s5_ff;
   logic [5:0]         s4_lead_ff;

   always_comb begin
      s3_spec_in = s2_spec_ff;
      s3_sval_in = s2_sval_ff;
      if (s2_sa_ff == s2_sb_ff) begin
         s3_sum_in = {1'b0, s2_ma_ff} + {1'b0, s2_mb_ff};
      end else begin
         s3_sum_in = {1'b0, s2_ma_ff} - {1'b0, s2_mb_ff};
         if (!s2_spec_ff && (s2_ma_ff == s2_mb_ff)) begin
            s3_spec_in = 1'b1;
            s3_sval_in = 32'h0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_spec_ff <= s1_spec_in;
         s1_sval_ff <= s1_sval_in;
         s1_bm_ff   <= s1_bm_in;
         s1_be_ff   <= s1_be_in;
         s1_sm_ff   <= s1_sm_in;
         s1_se_ff   <= s1_se_in;
         s1_sa_ff   <= s1_sa_in;
         s1_sb_ff   <= s1_sb_in;
         s2_ma_ff   <= {s1_bm_ff, 30'b0};
         s2_mb_ff   <= s2_mb_in;
         s2_e_ff    <= s1_be_ff - 12'sd30;
         s2_sa_ff   <= s1_sa_ff;
         s2_sb_ff   <= s1_sb_ff;
         s2_spec_ff <= s1_spec_ff;
         s2_sval_ff <= s1_sval_ff;
         s3_m_ff    <= {9'b0, s3_sum_in};
         s3_e_ff    <= s2_e_ff;
         s3_s_ff    <= s2_sa_ff;
         s3_spec_ff <= s3_spec_in;
         s3_sval_ff <= s3_sval_in;
         s4_m_ff    <= s3_m_ff;
         s4_e_ff    <= s3_e_ff;
         s4_s_ff    <= s3_s_ff;
         s4_spec_ff <= s3_spec_ff;
         s4_sval_ff <= s3_sval_ff;
         s4_lead_ff <= lead_one(s3_m_ff);
         s5_ff      <= s4_spec_ff ? s4_sval_ff
                                  : round_pack(s4_s_ff, s4_e_ff, s4_lead_ff, s4_m_ff);
      end
   end

   fisr_fmul u_step (.clock(clock), .en(en), .a(guess_ff[13]), .b(s5_ff), .y(res_w));

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= zero_ff[DEPTH-2] ? 32'h0 : res_w;
      end
   end

   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign rsp_tdata  = out_ff;

endmodule

`default_nettype wire

>>> rtl/core/fisr_checker.sv
// ----------------------------------------------------------------------------
// fisr_checker
// Port-level checks on the reciprocal square root block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fast_inverse_square_root_assert.svh"

module fisr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // an offered transaction stays put until it is taken
   `FISR_ASSERT_NEXT(a_req_hold, clock, reset, req_tvalid && !req_tready, req_tvalid && $stable(req_tdata))

   // a waiting result holds its data
   `FISR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // the whole pipeline advances exactly when the output can move
   `FISR_ASSERT_NOW(a_ready_rule, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))

   // reset empties the pipeline
   `FISR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind fast_inverse_square_root fisr_checker u_fisr_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

`default_nettype wire
